### src/stft_pkg.sv
package stft_pkg;

    localparam int WINDOW_SIZE = 128;
    localparam int FFT_SIZE    = 128;
    localparam int FFT_LOG2    = 7;
    localparam int NUM_BINS    = FFT_SIZE / 2;
    localparam int DATA_W      = 26;
    localparam int COEF_W      = 32;
    localparam int WIN_W       = 17;
    localparam int MAG_W       = 22;
    localparam int SQ_W        = 53;

    localparam logic [MAG_W-1:0] MAG_MAX = 22'h3FFFFF;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] HAMM_A_Q30 = 64'sd579820585;
    localparam logic signed [63:0] HAMM_B_Q30 = 64'sd493921239;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t tw_tab_t [NUM_BINS];
    typedef logic [WIN_W-1:0] win_tab_t [WINDOW_SIZE];

    // cosine over a quarter turn, Taylor series in Q30, clamped to [0, 1]
    function automatic logic [63:0] cos_quarter(input logic [63:0] r);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] u;
        th = (r * HALF_PI_Q30) >> 30;
        x2 = (th * th) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        u  = ((x2 * t) >> 30) >> 1;
        if (u > Q30_ONE)
            return 64'd0;
        return Q30_ONE - u;
    endfunction

    // cosine of a phase in turns with a 32-bit fraction, signed Q30
    function automatic logic signed [63:0] cos_turn(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] rq;
        r  = {34'd0, p[29:0]};
        rq = Q30_ONE - r;
        case (p[31:30])
            2'd0:    return $signed(cos_quarter(r));
            2'd1:    return -$signed(cos_quarter(rq));
            2'd2:    return -$signed(cos_quarter(r));
            default: return $signed(cos_quarter(rq));
        endcase
    endfunction

    function automatic win_tab_t make_win();
        win_tab_t tab;
        logic [63:0] p;
        logic signed [63:0] c;
        logic signed [63:0] w30;
        logic signed [63:0] w15;
        for (int n = 0; n < WINDOW_SIZE; n++) begin
            p   = ((64'(n) << 32) + 64'((WINDOW_SIZE - 1) / 2)) / 64'(WINDOW_SIZE - 1);
            c   = cos_turn(p[31:0]);
            w30 = HAMM_A_Q30 - ((HAMM_B_Q30 * c + 64'sd536870912) >>> 30);
            w15 = (w30 + 64'sd16384) >>> 15;
            tab[n] = w15[WIN_W-1:0];
        end
        return tab;
    endfunction

    function automatic tw_tab_t make_tw_re();
        tw_tab_t tab;
        logic signed [63:0] c;
        for (int k = 0; k < NUM_BINS; k++) begin
            c = cos_turn(32'((64'(k) << 32) / 64'(FFT_SIZE)));
            tab[k] = c[COEF_W-1:0];
        end
        return tab;
    endfunction

    function automatic tw_tab_t make_tw_im();
        tw_tab_t tab;
        logic signed [63:0] c;
        logic [31:0] pp;
        for (int k = 0; k < NUM_BINS; k++) begin
            pp = 32'((64'(k) << 32) / 64'(FFT_SIZE));
            c  = -cos_turn(pp - 32'h40000000);
            tab[k] = c[COEF_W-1:0];
        end
        return tab;
    endfunction

    localparam win_tab_t WIN_ROM   = make_win();
    localparam tw_tab_t  TW_RE_ROM = make_tw_re();
    localparam tw_tab_t  TW_IM_ROM = make_tw_im();

    function automatic logic [FFT_LOG2-1:0] bit_rev(input logic [FFT_LOG2-1:0] v);
        logic [FFT_LOG2-1:0] r;
        for (int b = 0; b < FFT_LOG2; b++)
            r[b] = v[FFT_LOG2-1-b];
        return r;
    endfunction

endpackage

### src/stft_magnitude_spectrogram.sv
// a sample that completes a frame starts the transform: the samples are windowed as they are loaded,
// then 448 butterflies run through the one shared multiplier, and then 64 magnitudes go
// through the bit-serial root unit
// no sample is taken while a frame is processed, including while the output stalls
// reset: hop 64, fill and skip counts zero, no word pending; history needs no clearing
module stft_magnitude_spectrogram
    import stft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [11:0]       hop_size,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic signed [15:0] sample,
    output logic              bin_valid,
    input  logic              bin_stall,
    output logic [5:0]        bin_index,
    output logic [MAG_W-1:0]  magnitude,
    output logic              last_bin
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_BFLY = 2'd2;
    localparam logic [1:0] S_MAG  = 2'd3;

    // control state
    logic [1:0]  state_reg, state_next;
    logic [11:0] hop_reg;
    logic [7:0]  fill_reg, fill_next;
    logic [11:0] skip_reg, skip_next;
    logic [6:0]  wp_reg, wp_next;
    logic [6:0]  idx_reg, idx_next;
    logic [2:0]  stage_reg, stage_next;
    logic [2:0]  phase_reg, phase_next;
    logic        out_valid_reg;

    // datapath
    logic [15:0]             hist_mem [WINDOW_SIZE];
    logic [15:0]             hist_rd_reg;
    logic [2*DATA_W-1:0]     fft_mem [FFT_SIZE];
    logic [2*DATA_W-1:0]     rd_a_reg, rd_b_reg;
    logic signed [57:0]      prod_reg;
    logic signed [58:0]      acc_reg, acc_next;
    logic signed [DATA_W-1:0] tr_reg, tr_next, ti_reg, ti_next;
    logic [SQ_W-1:0]         sq_v_reg, sq_v_next, sq_res_reg, sq_res_next;
    logic [SQ_W-1:0]         sq_bit_reg, sq_bit_next;
    logic [5:0]              bin_index_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    last_reg;

    logic                    sample_accept;
    logic                    hist_we;
    logic                    fft_re;
    logic                    fft_we;
    logic [6:0]              fft_waddr;
    logic [2*DATA_W-1:0]     fft_wdata;
    logic [6:0]              rd_addr_a, rd_addr_b;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic                    out_load;

    logic [6:0]              half_mask, bf_k, bf_a, bf_b;
    logic [5:0]              tw_ix;
    logic signed [COEF_W-1:0] tw_re, tw_im;
    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;
    logic signed [58:0]      acc_rnd;
    logic signed [DATA_W-1:0] rnd30;
    logic signed [57:0]      prod_rnd;
    logic [SQ_W:0]           sq_sum;
    logic [SQ_W-1:0]         sq_final;
    logic [MAG_W-1:0]        mag_sat;
    logic [11:0]             hop_eff;
    logic [7:0]              fill_inc;

    assign cfg_ready     = 1'b1;
    assign sample_stall  = (state_reg != S_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign bin_valid     = out_valid_reg;
    assign bin_index     = bin_index_reg;
    assign magnitude     = mag_reg;
    assign last_bin      = last_reg;

    // butterfly addressing for the current stage
    assign half_mask = 7'((7'd1 << stage_reg) - 7'd1);
    assign bf_k      = {1'b0, idx_reg[5:0]} & half_mask;
    assign bf_a      = 7'((({1'b0, idx_reg[5:0]} & ~half_mask) << 1) | bf_k);
    assign bf_b      = bf_a | 7'(7'd1 << stage_reg);
    assign tw_ix     = 6'(bf_k << (3'd6 - stage_reg));
    assign tw_re     = TW_RE_ROM[tw_ix];
    assign tw_im     = TW_IM_ROM[tw_ix];

    assign a_re = $signed(rd_a_reg[2*DATA_W-1:DATA_W]);
    assign a_im = $signed(rd_a_reg[DATA_W-1:0]);
    assign b_re = $signed(rd_b_reg[2*DATA_W-1:DATA_W]);
    assign b_im = $signed(rd_b_reg[DATA_W-1:0]);

    // rounding of the twiddle product and of the windowed sample
    assign acc_rnd  = (acc_reg + 59'sd536870912) >>> 30;
    assign rnd30    = acc_rnd[DATA_W-1:0];
    assign prod_rnd = (prod_reg + 58'sd16384) >>> 15;

    // root step and final rounding
    assign sq_sum   = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_final = sq_res_reg + SQ_W'(sq_v_reg > sq_res_reg);
    assign mag_sat  = (sq_final > SQ_W'(MAG_MAX)) ? MAG_MAX : sq_final[MAG_W-1:0];

    assign hop_eff  = (hop_reg == 12'd0) ? 12'd1 : hop_reg;
    assign fill_inc = (fill_reg < 8'(WINDOW_SIZE)) ? fill_reg + 8'd1 : fill_reg;

    assign out_load = (state_reg == S_MAG) && (phase_reg == 3'd5)
                      && (!out_valid_reg || !bin_stall);

    // multiplier operand select
    always_comb
    begin
        mul_a = b_re;
        mul_b = tw_re;
        case (state_reg)
            S_LOAD:
            begin
                mul_a = DATA_W'($signed(hist_rd_reg));
                mul_b = $signed({15'd0, WIN_ROM[idx_reg]});
            end
            S_BFLY:
            begin
                case (phase_reg)
                    3'd1:    begin mul_a = b_re; mul_b = tw_re; end
                    3'd2:    begin mul_a = b_im; mul_b = tw_im; end
                    3'd3:    begin mul_a = b_re; mul_b = tw_im; end
                    default: begin mul_a = b_im; mul_b = tw_re; end
                endcase
            end
            S_MAG:
            begin
                if (phase_reg == 3'd1)
                begin
                    mul_a = a_re;
                    mul_b = COEF_W'(a_re);
                end
                else
                begin
                    mul_a = a_im;
                    mul_b = COEF_W'(a_im);
                end
            end
            default:
            begin
                mul_a = b_re;
                mul_b = tw_re;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        skip_next   = skip_reg;
        wp_next     = wp_reg;
        idx_next    = idx_reg;
        stage_next  = stage_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        tr_next     = tr_reg;
        ti_next     = ti_reg;
        sq_v_next   = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        hist_we     = 1'b0;
        fft_re      = 1'b0;
        fft_we      = 1'b0;
        fft_waddr   = bf_a;
        fft_wdata   = '0;
        rd_addr_a   = bf_a;
        rd_addr_b   = bf_b;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_accept)
                begin
                    if (skip_reg != 12'd0)
                        skip_next = skip_reg - 12'd1;
                    else
                    begin
                        hist_we   = 1'b1;
                        wp_next   = wp_reg + 7'd1;
                        fill_next = fill_inc;
                        if (fill_inc == 8'(WINDOW_SIZE))
                        begin
                            state_next = S_LOAD;
                            idx_next   = '0;
                            phase_next = '0;
                            if (hop_eff <= 12'(WINDOW_SIZE))
                            begin
                                fill_next = 8'(12'(WINDOW_SIZE) - hop_eff);
                                skip_next = '0;
                            end
                            else
                            begin
                                fill_next = '0;
                                skip_next = hop_eff - 12'(WINDOW_SIZE);
                            end
                        end
                    end
                end
            end
            S_LOAD:
            begin
                case (phase_reg)
                    3'd0:    phase_next = 3'd1;
                    3'd1:    phase_next = 3'd2;
                    default:
                    begin
                        fft_we     = 1'b1;
                        fft_waddr  = bit_rev(idx_reg);
                        fft_wdata  = {prod_rnd[DATA_W-1:0], {DATA_W{1'b0}}};
                        phase_next = 3'd0;
                        idx_next   = idx_reg + 7'd1;
                        if (idx_reg == 7'(WINDOW_SIZE - 1))
                        begin
                            state_next = S_BFLY;
                            idx_next   = '0;
                            stage_next = '0;
                        end
                    end
                endcase
            end
            S_BFLY:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd0: fft_re = 1'b1;
                    3'd1: ;
                    3'd2: acc_next = 59'(prod_reg);
                    3'd3: acc_next = acc_reg - 59'(prod_reg);
                    3'd4:
                    begin
                        tr_next  = rnd30;
                        acc_next = 59'(prod_reg);
                    end
                    3'd5: acc_next = acc_reg + 59'(prod_reg);
                    3'd6:
                    begin
                        ti_next   = rnd30;
                        fft_we    = 1'b1;
                        fft_waddr = bf_a;
                        fft_wdata = {DATA_W'(a_re + tr_reg), DATA_W'(a_im + rnd30)};
                    end
                    default:
                    begin
                        fft_we    = 1'b1;
                        fft_waddr = bf_b;
                        fft_wdata = {DATA_W'(a_re - tr_reg), DATA_W'(a_im - ti_reg)};
                        idx_next  = {1'b0, idx_reg[5:0] + 6'd1};
                        if (idx_reg[5:0] == 6'(NUM_BINS - 1))
                        begin
                            idx_next   = '0;
                            stage_next = stage_reg + 3'd1;
                            if (stage_reg == 3'(FFT_LOG2 - 1))
                                state_next = S_MAG;
                        end
                    end
                endcase
            end
            S_MAG:
            begin
                rd_addr_a = idx_reg;
                case (phase_reg)
                    3'd0:
                    begin
                        fft_re     = 1'b1;
                        phase_next = 3'd1;
                    end
                    3'd1: phase_next = 3'd2;
                    3'd2:
                    begin
                        acc_next   = 59'(prod_reg);
                        phase_next = 3'd3;
                    end
                    3'd3:
                    begin
                        sq_v_next   = SQ_W'(acc_reg + 59'(prod_reg));
                        sq_res_next = '0;
                        sq_bit_next = SQ_W'(1) << (SQ_W - 1);
                        phase_next  = 3'd4;
                    end
                    3'd4:
                    begin
                        if (sq_bit_reg == '0)
                            phase_next = 3'd5;
                        else
                        begin
                            if ({1'b0, sq_v_reg} >= sq_sum)
                            begin
                                sq_v_next   = sq_v_reg - sq_sum[SQ_W-1:0];
                                sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                            end
                            else
                                sq_res_next = sq_res_reg >> 1;
                            sq_bit_next = sq_bit_reg >> 2;
                        end
                    end
                    default:
                    begin
                        if (out_load)
                        begin
                            phase_next = 3'd0;
                            idx_next   = idx_reg + 7'd1;
                            if (idx_reg == 7'(NUM_BINS - 1))
                            begin
                                state_next = S_IDLE;
                                idx_next   = '0;
                            end
                        end
                    end
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hop_reg       <= 12'd64;
            fill_reg      <= '0;
            skip_reg      <= '0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            stage_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            skip_reg  <= skip_next;
            wp_reg    <= wp_next;
            idx_reg   <= idx_next;
            stage_reg <= stage_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready)
                hop_reg <= hop_size;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!bin_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic and output word registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= mul_a * mul_b;
        acc_reg    <= acc_next;
        tr_reg     <= tr_next;
        ti_reg     <= ti_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        if (out_load)
        begin
            bin_index_reg <= idx_reg[5:0];
            mag_reg       <= mag_sat;
            last_reg      <= (idx_reg == 7'(NUM_BINS - 1));
        end
    end

    // sample history, circular with the oldest sample at the write pointer
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wp_reg] <= sample;
        hist_rd_reg <= hist_mem[7'(wp_reg + idx_reg)];
    end

    // transform working memory
    always_ff @(posedge clk)
    begin
        if (fft_we)
            fft_mem[fft_waddr] <= fft_wdata;
        if (fft_re)
        begin
            rd_a_reg <= fft_mem[rd_addr_a];
            rd_b_reg <= fft_mem[rd_addr_b];
        end
    end

endmodule
